FILE: rtl/ucd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucd_pkg: shared widths and constants
// Field widths, calendar constants and reciprocal factors for the
// millisecond-to-UTC date/time converter.
// ----------------------------------------------------------------------------
package ucd_pkg;

  // result field widths
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned MSEC_W  = 10;

  // internal widths
  localparam int unsigned R400_W = 44;  // ms remainder inside a 400-year cycle
  localparam int unsigned HEAD_W = 43;  // 2^43 < ms per 400 years
  localparam int unsigned D400_W = 18;  // day inside a 400-year cycle
  localparam int unsigned MSD_W  = 27;  // ms of day
  localparam int unsigned SOD_W  = 17;  // second of day
  localparam int unsigned REM_W  = 12;  // second of hour
  localparam int unsigned N2_W   = 16;  // day inside a 100-year cycle
  localparam int unsigned N3_W   = 11;  // day inside a 4-year cycle
  localparam int unsigned Q4_W   = 5;
  localparam int unsigned DOY_W  = 9;

  // ms from 1601-01-01 to 1970-01-01, and per 400-year cycle / per day / per second
  localparam logic [R400_W-1:0] OFFSET_MS   = 44'd11644473600000;
  localparam logic [R400_W-1:0] MS_PER_400Y = 44'd12622780800000;
  localparam logic [MSD_W-1:0]  MS_PER_DAY  = 27'd86400000;
  localparam logic [MSD_W-1:0]  MS_PER_SEC  = 27'd1000;

  // day thresholds
  localparam logic [D400_W-1:0] DAYS_100Y = 18'd36524;
  localparam logic [D400_W-1:0] DAYS_200Y = 18'd73048;
  localparam logic [D400_W-1:0] DAYS_300Y = 18'd109572;
  localparam logic [N2_W-1:0]   DAYS_4Y   = 16'd1461;
  localparam logic [N3_W-1:0]   DAYS_1Y   = 11'd365;
  localparam logic [N3_W-1:0]   DAYS_2Y   = 11'd730;
  localparam logic [N3_W-1:0]   DAYS_3Y   = 11'd1095;
  localparam logic [SOD_W-1:0]  SEC_PER_HOUR = 17'd3600;
  localparam logic [REM_W-1:0]  SEC_PER_MIN  = 12'd60;

  // reciprocals: q = (n * RCP) >> SH, exact over the value ranges used
  localparam int unsigned       RCP_SEC_W  = 28;
  localparam logic [27:0]       RCP_SEC    = 28'd137438954;  // /1000, n < 86400000
  localparam int unsigned       SH_SEC     = 37;
  localparam int unsigned       RCP_4Y_W   = 17;
  localparam logic [16:0]       RCP_4Y     = 17'd91868;      // /1461, n <= 36525
  localparam int unsigned       SH_4Y      = 27;
  localparam int unsigned       RCP_HOUR_W = 16;
  localparam logic [15:0]       RCP_HOUR   = 16'd37283;      // /3600, n < 86400
  localparam int unsigned       SH_HOUR    = 27;
  localparam int unsigned       RCP_MIN_W  = 13;
  localparam logic [12:0]       RCP_MIN    = 13'd4370;       // /60, n < 3600
  localparam int unsigned       SH_MIN     = 18;

  localparam logic [YEAR_W-1:0] YEAR_BASE    = 14'd1601;
  localparam logic [YEAR_W-1:0] YEARS_400    = 14'd400;
  localparam logic [YEAR_W-1:0] YEARS_100    = 14'd100;
  localparam logic [Q4_W-1:0]   LAST_Q4      = 5'd24;

  // first day of each month, non-leap year
  localparam logic [DOY_W-1:0] MONTH_FIRST_DOY [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

endpackage

FILE: rtl/ucd_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucd_stream_if: valid/ready channels of the converter
// Input word carries the ms timestamp, output word the date and time.
// ----------------------------------------------------------------------------
interface ucd_in_if #(
  parameter int unsigned MILLIS_WIDTH = 48
) ();
  logic                    valid;
  logic                    ready;
  logic [MILLIS_WIDTH-1:0] epoch_millis;

  modport source (output valid, output epoch_millis, input ready);
  modport sink   (input valid, input epoch_millis, output ready);
endinterface

interface ucd_out_if import ucd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  cal_year;
  logic [MONTH_W-1:0] cal_month;
  logic [DAY_W-1:0]   cal_day;
  logic [HOUR_W-1:0]  clock_hour;
  logic [MIN_W-1:0]   clock_minute;
  logic [SEC_W-1:0]   clock_second;
  logic [MSEC_W-1:0]  clock_millis;

  modport source (
    output valid, output cal_year, output cal_month, output cal_day,
    output clock_hour, output clock_minute, output clock_second,
    output clock_millis, input ready
  );
  modport sink (
    input valid, input cal_year, input cal_month, input cal_day,
    input clock_hour, input clock_minute, input clock_second,
    input clock_millis, output ready
  );
endinterface

FILE: rtl/ucd_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucd_div_pipe: pipelined restoring division by a constant
// Shifts the top STEPS bits of x through the remainder, one quotient bit per
// step, SPS steps per register stage. Low bits of x ride along and end up on
// top, with the quotient in the low STEPS bits.
// ----------------------------------------------------------------------------
module ucd_div_pipe #(
  parameter int unsigned R_W     = 27,
  parameter int unsigned X_W     = 24,
  parameter int unsigned STEPS   = 18,
  parameter logic [63:0] DIVISOR = 64'd86400000,
  parameter int unsigned SPS     = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [R_W-1:0] in_rem_i,   // must be below DIVISOR
  input  logic [X_W-1:0] in_x_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [R_W-1:0] out_rem_o,
  output logic [X_W-1:0] out_x_o
);

  localparam int unsigned NREG    = (STEPS + SPS - 1) / SPS;
  localparam logic [R_W:0] DIV_EXT = (R_W + 1)'(DIVISOR);

  logic [NREG-1:0] vld_q;
  logic [NREG-1:0] vld_s;
  logic [NREG-1:0] adv;
  logic [R_W-1:0]  rem_q [NREG];
  logic [X_W-1:0]  x_q   [NREG];
  logic [R_W-1:0]  rem_s [NREG];
  logic [X_W-1:0]  x_s   [NREG];
  logic [R_W-1:0]  rem_d [NREG];
  logic [X_W-1:0]  x_d   [NREG];

  for (genvar g = 0; g < NREG; g++) begin : g_stage
    if (g == 0) begin : g_head
      assign rem_s[g] = in_rem_i;
      assign x_s[g]   = in_x_i;
      assign vld_s[g] = in_valid_i;
    end else begin : g_body
      assign rem_s[g] = rem_q[g-1];
      assign x_s[g]   = x_q[g-1];
      assign vld_s[g] = vld_q[g-1];
    end

    if (g == NREG - 1) begin : g_tail
      assign adv[g] = !vld_q[g] || out_ready_i;
    end else begin : g_mid
      assign adv[g] = !vld_q[g] || adv[g+1];
    end

    always_comb begin
      logic [R_W:0]   v;
      logic [R_W-1:0] r;
      logic [X_W-1:0] x;
      logic           qb;
      v  = '0;
      qb = 1'b0;
      r  = rem_s[g];
      x  = x_s[g];
      for (int unsigned k = 0; k < SPS; k++) begin
        if (g * SPS + k < STEPS) begin
          v  = {r, x[X_W-1]};
          qb = (v >= DIV_EXT);
          r  = qb ? R_W'(v - DIV_EXT) : v[R_W-1:0];
          x  = {x[X_W-2:0], qb};
        end
      end
      rem_d[g] = r;
      x_d[g]   = x;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (adv[g]) begin
        vld_q[g] <= vld_s[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[g]) begin
        rem_q[g] <= rem_d[g];
        x_q[g]   <= x_d[g];
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NREG-1];
  assign out_rem_o   = rem_q[NREG-1];
  assign out_x_o     = x_q[NREG-1];

endmodule

FILE: rtl/unix_ms_to_utc_datetime_top.sv
`timescale 1ns / 1ps
// Stages from input word to output word: one offset-add stage,
//   max(MILLIS_WIDTH,44) - 42 stages of the 400-year divider, nine of the day
//   divider, six calendar stages. Throughput: one word per cycle unless stalled;
//   every stage holds a valid bit and advances when the stage after it is empty
//   or moving, so a stall loses and repeats nothing.
// Reset clears the valid bits only; the datapath registers are not reset.
// ----------------------------------------------------------------------------
// unix_ms_to_utc_datetime_top: ms since 1970 to proleptic Gregorian UTC
// Offsets the timestamp to 1601-01-01, splits it into 400-year cycles and
// ms of day by long division, then resolves 100/4/1-year cycles, month and
// time of day with compares, a month-start table and reciprocal multiplies.
// ----------------------------------------------------------------------------
module unix_ms_to_utc_datetime_top import ucd_pkg::*; #(
  parameter int unsigned MILLIS_WIDTH = 48
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ucd_in_if.sink    ms_i,
  ucd_out_if.source dt_o
);

  // Offset timestamp width, and the 400-year quotient width that is left over
  // once the top HEAD_W bits (always below one cycle) seed the remainder.
  localparam int unsigned X1_W = ((MILLIS_WIDTH > R400_W) ? MILLIS_WIDTH : R400_W) + 1;
  localparam int unsigned Q_W  = X1_W - HEAD_W;
  localparam int unsigned X2_W = D400_W + Q_W;

  // --------------------------------------------------------------------------
  // Stage types
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [MSD_W-1:0]  msd;
    logic [SOD_W-1:0]  sec;
    logic [YEAR_W-1:0] q400;   // low bits of the 400-year count
    logic [1:0]        q100;
    logic [N2_W-1:0]   n2;
  } s1_t;

  typedef struct packed {
    logic [SOD_W-1:0]  sec;
    logic [MSEC_W-1:0] millis;
    logic [YEAR_W-1:0] q400;
    logic [1:0]        q100;
    logic [N2_W-1:0]   n2;
    logic [Q4_W-1:0]   q4;
  } s2_t;

  typedef struct packed {
    logic [SOD_W-1:0]  sec;
    logic [MSEC_W-1:0] millis;
    logic [HOUR_W-1:0] hour;
    logic [YEAR_W-1:0] q400;
    logic [1:0]        q100;
    logic [Q4_W-1:0]   q4;
    logic [N3_W-1:0]   n3;
  } s3_t;

  typedef struct packed {
    logic [MSEC_W-1:0] millis;
    logic [HOUR_W-1:0] hour;
    logic [REM_W-1:0]  soh;    // second of hour
    logic [YEAR_W-1:0] year;
    logic              leap;
    logic [DOY_W-1:0]  doy;    // day of year from 0
  } s4_t;

  typedef struct packed {
    logic [MSEC_W-1:0]  millis;
    logic [HOUR_W-1:0]  hour;
    logic [REM_W-1:0]   soh;
    logic [MIN_W-1:0]   minute;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } s5_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [MSEC_W-1:0]  millis;
  } s6_t;

  // --------------------------------------------------------------------------
  // Stage 0: move the epoch to 1601-01-01 (start of a 400-year cycle)
  // --------------------------------------------------------------------------
  logic            s0_vld_q;
  logic            s0_adv;
  logic [X1_W-1:0] s0_x_q;
  logic            d1_in_ready;

  assign s0_adv   = !s0_vld_q || d1_in_ready;
  assign ms_i.ready = s0_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (s0_adv) begin
      s0_vld_q <= ms_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_adv) begin
      s0_x_q <= X1_W'(MILLIS_WIDTH'(ms_i.epoch_millis)) + X1_W'(OFFSET_MS);
    end
  end

  // --------------------------------------------------------------------------
  // Divider 1: offset ms / ms per 400 years -> 400-year count, ms remainder
  // --------------------------------------------------------------------------
  logic              d1_out_valid;
  logic              d2_in_ready;
  logic [R400_W-1:0] d1_rem;
  logic [Q_W-1:0]    d1_x;

  ucd_div_pipe #(
    .R_W     (R400_W),
    .X_W     (Q_W),
    .STEPS   (Q_W),
    .DIVISOR (64'(MS_PER_400Y)),
    .SPS     (1)
  ) u_div_400y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s0_vld_q),
    .in_ready_o  (d1_in_ready),
    .in_rem_i    (R400_W'(s0_x_q[X1_W-1 -: HEAD_W])),
    .in_x_i      (s0_x_q[Q_W-1:0]),
    .out_valid_o (d1_out_valid),
    .out_ready_i (d2_in_ready),
    .out_rem_o   (d1_rem),
    .out_x_o     (d1_x)
  );

  // --------------------------------------------------------------------------
  // Divider 2: ms in cycle / ms per day -> day in cycle, ms of day.
  // The top bits of the remainder are below one day and seed the partial
  // remainder; the 400-year count rides along in the low bits.
  // --------------------------------------------------------------------------
  logic             d2_out_valid;
  logic             s1_adv;
  logic [MSD_W-1:0] d2_msd;
  logic [X2_W-1:0]  d2_x;

  ucd_div_pipe #(
    .R_W     (MSD_W),
    .X_W     (X2_W),
    .STEPS   (D400_W),
    .DIVISOR (64'(MS_PER_DAY)),
    .SPS     (2)
  ) u_div_day (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d1_out_valid),
    .in_ready_o  (d2_in_ready),
    .in_rem_i    (MSD_W'(d1_rem[R400_W-1:D400_W])),
    .in_x_i      ({d1_rem[D400_W-1:0], d1_x}),
    .out_valid_o (d2_out_valid),
    .out_ready_i (s1_adv),
    .out_rem_o   (d2_msd),
    .out_x_o     (d2_x)
  );

  // --------------------------------------------------------------------------
  // Calendar stages: valid bits and advance chain
  // --------------------------------------------------------------------------
  logic [5:0] pv_q;
  logic [5:0] padv;

  assign padv[5] = !pv_q[5] || dt_o.ready;
  assign padv[4] = !pv_q[4] || padv[5];
  assign padv[3] = !pv_q[3] || padv[4];
  assign padv[2] = !pv_q[2] || padv[3];
  assign padv[1] = !pv_q[1] || padv[2];
  assign padv[0] = !pv_q[0] || padv[1];
  assign s1_adv  = padv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else begin
      if (padv[0]) pv_q[0] <= d2_out_valid;
      if (padv[1]) pv_q[1] <= pv_q[0];
      if (padv[2]) pv_q[2] <= pv_q[1];
      if (padv[3]) pv_q[3] <= pv_q[2];
      if (padv[4]) pv_q[4] <= pv_q[3];
      if (padv[5]) pv_q[5] <= pv_q[4];
    end
  end

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;
  s6_t s6_d, s6_q;

  // S1: second of day; 100-year cycle, clamped so the cycle's last day stays
  // in the fourth century.
  always_comb begin
    logic [MSD_W+RCP_SEC_W-1:0] p;
    logic [D400_W-1:0]          d400;
    d400     = d2_x[D400_W-1:0];
    p        = (MSD_W + RCP_SEC_W)'(d2_msd) * (MSD_W + RCP_SEC_W)'(RCP_SEC);
    s1_d.msd  = d2_msd;
    s1_d.sec  = p[SH_SEC +: SOD_W];
    s1_d.q400 = YEAR_W'(d2_x[X2_W-1:D400_W]);
    if (d400 >= DAYS_300Y) begin
      s1_d.q100 = 2'd3;
      s1_d.n2   = N2_W'(d400 - DAYS_300Y);
    end else if (d400 >= DAYS_200Y) begin
      s1_d.q100 = 2'd2;
      s1_d.n2   = N2_W'(d400 - DAYS_200Y);
    end else if (d400 >= DAYS_100Y) begin
      s1_d.q100 = 2'd1;
      s1_d.n2   = N2_W'(d400 - DAYS_100Y);
    end else begin
      s1_d.q100 = 2'd0;
      s1_d.n2   = N2_W'(d400);
    end
  end

  // S2: millisecond of second; 4-year cycle count
  always_comb begin
    logic [N2_W+RCP_4Y_W-1:0] p;
    p           = (N2_W + RCP_4Y_W)'(s1_q.n2) * (N2_W + RCP_4Y_W)'(RCP_4Y);
    s2_d.sec    = s1_q.sec;
    s2_d.millis = MSEC_W'(s1_q.msd - MSD_W'(MSD_W'(s1_q.sec) * MS_PER_SEC));
    s2_d.q400   = s1_q.q400;
    s2_d.q100   = s1_q.q100;
    s2_d.n2     = s1_q.n2;
    s2_d.q4     = p[SH_4Y +: Q4_W];
  end

  // S3: hour; day inside the 4-year cycle
  always_comb begin
    logic [SOD_W+RCP_HOUR_W-1:0] p;
    p           = (SOD_W + RCP_HOUR_W)'(s2_q.sec) * (SOD_W + RCP_HOUR_W)'(RCP_HOUR);
    s3_d.sec    = s2_q.sec;
    s3_d.millis = s2_q.millis;
    s3_d.hour   = p[SH_HOUR +: HOUR_W];
    s3_d.q400   = s2_q.q400;
    s3_d.q100   = s2_q.q100;
    s3_d.q4     = s2_q.q4;
    s3_d.n3     = N3_W'(s2_q.n2 - N2_W'(N2_W'(s2_q.q4) * DAYS_4Y));
  end

  // S4: second of hour; year inside the 4-year cycle (clamped), day of year,
  // leap flag and year number. A leap year is the last of a 4-year cycle,
  // except the last 4-year cycle of a century that is not the fourth.
  always_comb begin
    logic [1:0] q1;
    s4_d.millis = s3_q.millis;
    s4_d.hour   = s3_q.hour;
    s4_d.soh    = REM_W'(s3_q.sec - SOD_W'(SOD_W'(s3_q.hour) * SEC_PER_HOUR));
    if (s3_q.n3 >= DAYS_3Y) begin
      q1       = 2'd3;
      s4_d.doy = DOY_W'(s3_q.n3 - DAYS_3Y);
    end else if (s3_q.n3 >= DAYS_2Y) begin
      q1       = 2'd2;
      s4_d.doy = DOY_W'(s3_q.n3 - DAYS_2Y);
    end else if (s3_q.n3 >= DAYS_1Y) begin
      q1       = 2'd1;
      s4_d.doy = DOY_W'(s3_q.n3 - DAYS_1Y);
    end else begin
      q1       = 2'd0;
      s4_d.doy = DOY_W'(s3_q.n3);
    end
    s4_d.leap = (q1 == 2'd3) && ((s3_q.q4 != LAST_Q4) || (s3_q.q100 == 2'd3));
    // year wraps to the field width, as the field does
    s4_d.year = YEAR_BASE + s3_q.q400 * YEARS_400 + YEAR_W'(s3_q.q100) * YEARS_100
              + YEAR_W'({s3_q.q4, 2'b00}) + YEAR_W'(q1);
  end

  // S5: minute; month and day from the month-start table
  always_comb begin
    logic [REM_W+RCP_MIN_W-1:0] p;
    logic [DOY_W-1:0]           start;
    logic [DOY_W-1:0]           s;
    p           = (REM_W + RCP_MIN_W)'(s4_q.soh) * (REM_W + RCP_MIN_W)'(RCP_MIN);
    s5_d.millis = s4_q.millis;
    s5_d.hour   = s4_q.hour;
    s5_d.soh    = s4_q.soh;
    s5_d.minute = p[SH_MIN +: MIN_W];
    s5_d.year   = s4_q.year;
    s5_d.month  = MONTH_W'(1);
    start       = '0;
    for (int m = 0; m < 12; m++) begin
      s = MONTH_FIRST_DOY[m] + DOY_W'(s4_q.leap && (m >= 2));
      if (s4_q.doy >= s) begin
        s5_d.month = MONTH_W'(m + 1);
        start      = s;
      end
    end
    s5_d.day = DAY_W'(s4_q.doy - start + DOY_W'(1));
  end

  // S6: second of minute; output word
  always_comb begin
    s6_d.year   = s5_q.year;
    s6_d.month  = s5_q.month;
    s6_d.day    = s5_q.day;
    s6_d.hour   = s5_q.hour;
    s6_d.minute = s5_q.minute;
    s6_d.second = SEC_W'(s5_q.soh - REM_W'(REM_W'(s5_q.minute) * SEC_PER_MIN));
    s6_d.millis = s5_q.millis;
  end

  always_ff @(posedge clk_i) begin
    if (padv[0]) s1_q <= s1_d;
    if (padv[1]) s2_q <= s2_d;
    if (padv[2]) s3_q <= s3_d;
    if (padv[3]) s4_q <= s4_d;
    if (padv[4]) s5_q <= s5_d;
    if (padv[5]) s6_q <= s6_d;
  end

  // --------------------------------------------------------------------------
  // Output word
  // --------------------------------------------------------------------------
  assign dt_o.valid        = pv_q[5];
  assign dt_o.cal_year     = s6_q.year;
  assign dt_o.cal_month    = s6_q.month;
  assign dt_o.cal_day      = s6_q.day;
  assign dt_o.clock_hour   = s6_q.hour;
  assign dt_o.clock_minute = s6_q.minute;
  assign dt_o.clock_second = s6_q.second;
  assign dt_o.clock_millis = s6_q.millis;

endmodule

FILE: rtl/ucd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucd_checker: port-level checks for the converter
// Output handshake, result ranges and no output word without a pending input.
// ----------------------------------------------------------------------------
module ucd_checker import ucd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [YEAR_W-1:0]  cal_year_i,
  input logic [MONTH_W-1:0] cal_month_i,
  input logic [DAY_W-1:0]   cal_day_i,
  input logic [HOUR_W-1:0]  clock_hour_i,
  input logic [MIN_W-1:0]   clock_minute_i,
  input logic [SEC_W-1:0]   clock_second_i,
  input logic [MSEC_W-1:0]  clock_millis_i
);

  // words accepted but not yet delivered
  logic [7:0] inflight_q, inflight_d;
  logic       in_acc, out_acc;

  assign in_acc     = in_valid_i && in_ready_i;
  assign out_acc    = out_valid_i && out_ready_i;
  assign inflight_d = inflight_q + 8'(in_acc) - 8'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(cal_year_i) && $stable(cal_month_i)
      && $stable(cal_day_i) && $stable(clock_hour_i) && $stable(clock_minute_i)
      && $stable(clock_second_i) && $stable(clock_millis_i))
    else $error("output word changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != 8'd0)
    else $error("output word without a pending input word");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cal_month_i >= 4'd1 && cal_month_i <= 4'd12 && cal_day_i >= 5'd1
      && !(cal_month_i == 4'd2 && cal_day_i > 5'd29)
      && !(cal_day_i == 5'd31 && (cal_month_i == 4'd4 || cal_month_i == 4'd6
           || cal_month_i == 4'd9 || cal_month_i == 4'd11)))
    else $error("date out of range");

  a_clock_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> clock_hour_i < 5'd24 && clock_minute_i < 6'd60
      && clock_second_i < 6'd60 && clock_millis_i < 10'd1000)
    else $error("time of day out of range");

endmodule

bind unix_ms_to_utc_datetime_top ucd_checker u_ucd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (ms_i.valid),
  .in_ready_i     (ms_i.ready),
  .out_valid_i    (dt_o.valid),
  .out_ready_i    (dt_o.ready),
  .cal_year_i     (dt_o.cal_year),
  .cal_month_i    (dt_o.cal_month),
  .cal_day_i      (dt_o.cal_day),
  .clock_hour_i   (dt_o.clock_hour),
  .clock_minute_i (dt_o.clock_minute),
  .clock_second_i (dt_o.clock_second),
  .clock_millis_i (dt_o.clock_millis)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: ms-since-1970 to UTC date/time converter
// Sends timestamp words through the valid/ready input under bursty traffic,
// recomputes each date and time in a behavioral predictor, and compares every
// output word field by field in order. The tests cover time-of-day rollovers,
// calendar corners (leap days, century years, cycle ends), a long output stall
// that backs up the pipeline, and a long random stream.
// ----------------------------------------------------------------------------
module testbench;
  import ucd_pkg::*;

  localparam int unsigned MILLIS_W     = 48;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned LATENCY      = 22;
  localparam int unsigned SETTLE       = LATENCY + 8;
  localparam int unsigned HOLD_CYCLES  = 400;  // long output stall
  localparam int unsigned IDLE_LIMIT   = 4000; // cycles with no word moving
  localparam int unsigned RANDOM_WORDS = 1600;
  localparam int unsigned PRINT_LIMIT  = 100;

  // calendar constants for the predictor
  localparam longint unsigned MS_PER_SECOND     = 1000;
  localparam longint unsigned SECONDS_PER_DAY   = 86400;
  localparam longint unsigned MS_PER_DAY_TB     = 86400000;
  localparam longint unsigned DAYS_1601_TO_1970 = 134774;
  localparam longint unsigned DAYS_IN_400Y      = 146097;
  localparam longint unsigned DAYS_IN_100Y      = 36524;
  localparam longint unsigned DAYS_IN_4Y        = 1461;
  localparam longint unsigned DAYS_IN_1Y        = 365;
  localparam int              LEAPS_THRU_1969   = 477;
  localparam int              LAST_FULL_YEAR    = 10888;
  localparam int MONTH_FIRST_DAY [12] = '{0, 31, 59, 90, 120, 151,
                                          181, 212, 243, 273, 304, 334};

  localparam logic [MILLIS_W-1:0] STAMP_MAX = '1;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [MSEC_W-1:0]  millis;
  } utc_date_t;

  typedef struct {
    logic [MILLIS_W-1:0] stamp;
    utc_date_t           date;
  } pending_date_t;

  logic clk;
  logic rst_n;

  ucd_in_if #(.MILLIS_WIDTH(MILLIS_W)) stamp_if ();
  ucd_out_if                           date_if ();

  unix_ms_to_utc_datetime_top #(
    .MILLIS_WIDTH(MILLIS_W)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .ms_i  (stamp_if),
    .dt_o  (date_if)
  );

  // dates still owed by the block, oldest first
  pending_date_t expected_dates[$];
  int unsigned   mismatch_count = 0;

  // sender pacing
  bit          pace_on    = 1'b1;
  int unsigned burst_left = 0;

  // set by a test to ask the receiver for one long stall
  bit hold_req = 1'b0;

  // --------------------------------------------------------------------------
  // Clock: 2 ns period
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: splits the day count into 400/100/4/1-year cycles from 1601,
  // clamping the 100- and 1-year quotients so the last day of a cycle stays in
  // the cycle's final (leap) year. Month from the month-start table, one day
  // added after February in a leap year.
  // --------------------------------------------------------------------------
  function automatic utc_date_t convert_stamp(input logic [MILLIS_W-1:0] stamp);
    longint unsigned ms_total, secs, day_num, sod, n;
    longint unsigned q400, q100, q4, q1, yr, doy, first_day, month_first;
    bit              leap_yr;
    int              mon;
    utc_date_t       d;
    ms_total = 64'(stamp);
    secs     = ms_total / MS_PER_SECOND;
    day_num  = secs / SECONDS_PER_DAY;
    sod      = secs % SECONDS_PER_DAY;
    n        = day_num + DAYS_1601_TO_1970;
    q400 = n / DAYS_IN_400Y;
    n    = n % DAYS_IN_400Y;
    q100 = n / DAYS_IN_100Y;
    if (q100 > 3) q100 = 3;
    n   -= q100 * DAYS_IN_100Y;
    q4   = n / DAYS_IN_4Y;
    n    = n % DAYS_IN_4Y;
    q1   = n / DAYS_IN_1Y;
    if (q1 > 3) q1 = 3;
    n   -= q1 * DAYS_IN_1Y;
    yr      = 1601 + 400 * q400 + 100 * q100 + 4 * q4 + q1;
    doy     = n;
    leap_yr = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    // table is increasing, so the last start not past doy picks the month
    mon         = 0;
    month_first = 0;
    for (int m = 0; m < 12; m++) begin
      first_day = MONTH_FIRST_DAY[m] + ((leap_yr && m >= 2) ? 1 : 0);
      if (doy >= first_day) begin
        mon         = m;
        month_first = first_day;
      end
    end
    d.year   = YEAR_W'(yr);
    d.month  = MONTH_W'(mon + 1);
    d.day    = DAY_W'(doy - month_first + 1);
    d.hour   = HOUR_W'(sod / 3600);
    d.minute = MIN_W'((sod % 3600) / 60);
    d.second = SEC_W'(sod % 60);
    d.millis = MSEC_W'(ms_total % MS_PER_SECOND);
    return d;
  endfunction

  // Timestamp of a given year, zero-based day of year and ms of day. Counts
  // leap days directly, independent of the cycle split above.
  function automatic logic [MILLIS_W-1:0] stamp_of_date(input int year, input int day_idx,
                                                        input longint unsigned ms_of_day);
    int              y1;
    longint unsigned days;
    y1   = year - 1;
    days = longint'(365 * (year - 1970)) + longint'(y1 / 4 - y1 / 100 + y1 / 400)
           - LEAPS_THRU_1969 + day_idx;
    return MILLIS_W'(days * MS_PER_DAY_TB + ms_of_day);
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting: one line each, printing capped, always counted
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string field, input logic [MILLIS_W-1:0] stamp,
                             input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("stamp %0d %s got %0d expected %0d",
                                stamp, field, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at a falling edge. Bursts of
  // random length separated by random gaps; a gap of zero keeps valid high.
  // --------------------------------------------------------------------------
  task automatic send_stamp(input logic [MILLIS_W-1:0] stamp);
    int unsigned gap;
    pending_date_t entry;
    if (pace_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          stamp_if.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
    end
    stamp_if.valid        <= 1'b1;
    stamp_if.epoch_millis <= stamp;
    do @(posedge clk); while (!stamp_if.ready);
    entry.stamp = stamp;
    entry.date  = convert_stamp(stamp);
    expected_dates.push_back(entry);
    @(negedge clk);
  endtask

  // Sender pause: drop valid and wait until every owed date has come out,
  // then let the pipeline empty.
  task automatic wait_for_drain();
    stamp_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_dates.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // ms/second/minute/hour/day rollovers and the raw field extremes
  task automatic test_time_of_day_edges();
    send_stamp('0);
    send_stamp(MILLIS_W'(999));
    send_stamp(MILLIS_W'(1000));
    send_stamp(MILLIS_W'(3599999));
    send_stamp(MILLIS_W'(86399999));
    send_stamp(MILLIS_W'(86400000));
    send_stamp(MILLIS_W'(64'd2147483648000));   // 2^31 seconds
    send_stamp(MILLIS_W'(64'hAAAA_AAAA_AAAA));
    send_stamp(MILLIS_W'(64'h5555_5555_5555));
    send_stamp(STAMP_MAX);                        // last ms the input can hold
    wait_for_drain();
  endtask

  // leap days, non-leap century, end of a 4-year cycle and of a 400-year
  // cycle (both clamp cases), far future years
  task automatic test_calendar_edges();
    send_stamp(stamp_of_date(1972, 59, 45296789));      // Feb 29 12:34:56.789
    send_stamp(stamp_of_date(1972, 365, 43200000));     // Dec 31, 4-year cycle end
    send_stamp(stamp_of_date(1999, 364, 86399999));
    send_stamp(stamp_of_date(2000, 59, 0));
    send_stamp(stamp_of_date(2000, 365, 86399999));     // 400-year cycle end
    send_stamp(stamp_of_date(2001, 0, 0));
    send_stamp(stamp_of_date(2023, 364, 0));
    send_stamp(stamp_of_date(2024, 60, 0));             // Mar 1 after leap day
    send_stamp(stamp_of_date(2100, 58, 86399999));      // century, no leap day
    send_stamp(stamp_of_date(2100, 59, 0));
    send_stamp(stamp_of_date(2400, 365, 0));
    send_stamp(stamp_of_date(10000, 0, 0));
    wait_for_drain();
  endtask

  // receiver stalls for a long stretch while words keep coming back to back
  task automatic test_backpressure();
    logic [63:0] raw;
    hold_req = 1'b1;
    pace_on  = 1'b0;
    for (int i = 0; i < 60; i++) begin
      raw = {$urandom(), $urandom()};
      send_stamp(raw[MILLIS_W-1:0]);
    end
    pace_on = 1'b1;
    wait_for_drain();
  endtask

  // dates near month/year boundaries for half the words, plus raw, small and near-max
  task automatic test_random_stream();
    logic [63:0]         raw;
    logic [MILLIS_W-1:0] stamp;
    int                  year, day_idx, last_day;
    longint unsigned     msod;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          raw   = {$urandom(), $urandom()};
          stamp = raw[MILLIS_W-1:0];
        end
        3: stamp = MILLIS_W'($urandom());
        4: stamp = STAMP_MAX - MILLIS_W'($urandom_range(0, 32'hFFFF_FFFF));
        default: begin
          year     = $urandom_range(1970, LAST_FULL_YEAR);
          last_day = ((year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0)))
                     ? 365 : 364;
          case ($urandom_range(0, 5))
            0:       day_idx = 0;
            1:       day_idx = 30;
            2:       day_idx = 58;
            3:       day_idx = 59;
            4:       day_idx = last_day;
            default: day_idx = $urandom_range(0, last_day);
          endcase
          case ($urandom_range(0, 3))
            0:       msod = 0;
            1:       msod = MS_PER_DAY_TB - 1;
            default: msod = $urandom_range(0, 86399999);
          endcase
          stamp = stamp_of_date(year, day_idx, msod);
        end
      endcase
      send_stamp(stamp);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready pattern changes mode every random stretch; on request it
  // holds ready low for HOLD_CYCLES, counted here.
  // --------------------------------------------------------------------------
  initial begin
    rx_mode_e    rx_mode;
    int unsigned stretch_left;
    int unsigned cycle_cnt;
    logic        rdy;
    rx_mode      = RX_ALWAYS;
    stretch_left = 0;
    cycle_cnt    = 0;
    date_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      cycle_cnt++;
      if (hold_req) begin
        hold_req = 1'b0;
        date_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (stretch_left == 0) begin
          rx_mode      = rx_mode_e'($urandom_range(0, 3));
          stretch_left = $urandom_range(10, 80);
        end
        stretch_left--;
        case (rx_mode)
          RX_ALWAYS:   rdy = 1'b1;
          RX_COIN:     rdy = 1'($urandom_range(0, 1));
          RX_SPARSE:   rdy = ($urandom_range(0, 3) == 0);
          RX_PERIODIC: rdy = (cycle_cnt % 5 != 4);
          default:     rdy = 1'b1;
        endcase
        date_if.ready <= rdy;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output checker: each accepted word against the oldest owed date
  // --------------------------------------------------------------------------
  initial begin
    pending_date_t want;
    forever begin
      @(posedge clk);
      if (rst_n && date_if.valid && date_if.ready) begin
        if (expected_dates.size() == 0) begin
          report_mismatch("output word with no date owed");
        end else begin
          want = expected_dates.pop_front();
          check_field("year",   want.stamp, 16'(date_if.cal_year),     16'(want.date.year));
          check_field("month",  want.stamp, 16'(date_if.cal_month),    16'(want.date.month));
          check_field("day",    want.stamp, 16'(date_if.cal_day),      16'(want.date.day));
          check_field("hour",   want.stamp, 16'(date_if.clock_hour),   16'(want.date.hour));
          check_field("minute", want.stamp, 16'(date_if.clock_minute), 16'(want.date.minute));
          check_field("second", want.stamp, 16'(date_if.clock_second), 16'(want.date.second));
          check_field("millis", want.stamp, 16'(date_if.clock_millis), 16'(want.date.millis));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too many cycles in a row with no word moving on either side
  // --------------------------------------------------------------------------
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((stamp_if.valid && stamp_if.ready) || (date_if.valid && date_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL unix_ms_to_utc_datetime_top");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset once, run the tests, drain, verdict
  // --------------------------------------------------------------------------
  initial begin
    stamp_if.valid        = 1'b0;
    stamp_if.epoch_millis = '0;
    rst_n                 = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    test_time_of_day_edges();
    test_calendar_edges();
    test_backpressure();
    test_random_stream();
    wait_for_drain();

    if (mismatch_count == 0) begin
      $display("PASS unix_ms_to_utc_datetime_top");
    end else begin
      $display("FAIL unix_ms_to_utc_datetime_top");
    end
    $finish;
  end

endmodule
